// ----- rtl/sar_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the serial ADC readout master.
// No dependencies; used by sar_seq and serial_adc_readout_master.
package sar_pkg;

	localparam int DELAY_W      = 8;   // width of the delay_ticks register
	localparam int CHAN_W       = 4;   // width of the channel field
	localparam int SAMPLE_W     = 10;  // width of the posted sample field
	localparam int EXTRA_CLOCKS = 6;   // clocks given after the address bits
	localparam int SLOW_BITS    = 2;   // data bits with a double-length high time

	// One tick on the input side
	typedef struct packed {
		logic                start_request;
		logic [CHAN_W-1:0]   channel_number;
		logic                data_out_level;
	} in_item_t;

	// Pin levels and status for one tick
	typedef struct packed {
		logic                chip_select_level;
		logic                io_clock_level;
		logic                address_level;
		logic                busy_flag;
		logic                sample_valid;
		logic [SAMPLE_W-1:0] sample_value;
	} out_item_t;

endpackage

// ----- rtl/serial_adc_readout_master.sv -----
`timescale 1ns / 1ps
// Top level of the serial ADC readout master: config register, sequencer, output register.
// Depends on sar_pkg and sar_seq.
// Output: the result for a tick is registered into the output register when the tick is transferred.
// Throughput: one tick per cycle; input is stalled only while a held result is stalled.
// Reset: idle, chip-select high, clock and address low, posted value zero, delay_ticks 1.
module serial_adc_readout_master #(
	parameter int ADDRESS_BITS = 4,
	parameter int RESULT_BITS  = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [sar_pkg::DELAY_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  sar_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output sar_pkg::out_item_t          out_data
);
	import sar_pkg::*;

	logic [DELAY_W-1:0] delay_ticks_q;
	logic               out_valid_q;
	out_item_t          out_q;
	out_item_t          res;
	logic               in_xfer;

	assign in_stall  = out_valid_q & out_stall;
	assign in_xfer   = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Delay configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ticks_q <= DELAY_W'(1);
		end else if (cfg_wr_en) begin
			delay_ticks_q <= cfg_wr_data;
		end
	end

	sar_seq #(
		.ADDRESS_BITS(ADDRESS_BITS),
		.RESULT_BITS (RESULT_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_en    (in_xfer),
		.item       (in_data),
		.delay_ticks(delay_ticks_q),
		.res        (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_q <= res;
		end
	end

endmodule

// ----- rtl/sar_seq.sv -----
`timescale 1ns / 1ps
// Conversion sequencer: phase machine, counters, shift registers and pin levels.
// Depends on sar_pkg. Advances one tick per accepted transfer.
module sar_seq #(
	parameter int ADDRESS_BITS = 4,
	parameter int RESULT_BITS  = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             tick_en,
	input  sar_pkg::in_item_t                item,
	input  logic [sar_pkg::DELAY_W-1:0]      delay_ticks,
	output sar_pkg::out_item_t               res
);
	import sar_pkg::*;

	localparam int MAX_CNT = (ADDRESS_BITS > RESULT_BITS) ?
		((ADDRESS_BITS > EXTRA_CLOCKS) ? ADDRESS_BITS : EXTRA_CLOCKS) :
		((RESULT_BITS > EXTRA_CLOCKS) ? RESULT_BITS : EXTRA_CLOCKS);
	localparam int CNT_W = $clog2(MAX_CNT + 1);
	localparam logic [CNT_W-1:0] CNT_ADDR  = CNT_W'(ADDRESS_BITS);
	localparam logic [CNT_W-1:0] CNT_EXTRA = CNT_W'(EXTRA_CLOCKS);
	localparam logic [CNT_W-1:0] CNT_SLOW  = CNT_W'(SLOW_BITS);
	localparam logic [CNT_W-1:0] CNT_FAST  = CNT_W'(RESULT_BITS - SLOW_BITS);

	typedef enum logic [3:0] {
		PH_IDLE, PH_SEL, PH_ASET, PH_AHI, PH_ALO, PH_XLO, PH_XHI, PH_PULSE,
		PH_SHI1, PH_SHI2, PH_SLO, PH_FHI, PH_FLO, PH_TAIL
	} phase_t;

	phase_t                    phase_q, phase_d;
	logic [CNT_W-1:0]          bit_cnt_q, bit_cnt_d, bit_cnt_dec;
	logic [DELAY_W-1:0]        dly_cnt_q, dly_cnt_d, dly_eff;
	logic [ADDRESS_BITS-1:0]   addr_sh_q, addr_sh_d, chan_masked;
	logic [RESULT_BITS-1:0]    data_sh_q, data_sh_d, data_shifted;
	logic [SAMPLE_W-1:0]       posted_q, posted_d, posted_from_sh;
	logic                      cs_q, cs_d, clk_q, clk_d, addr_q, addr_d;
	logic                      valid_d;
	logic [ADDRESS_BITS+CHAN_W-1:0]    chan_ext;
	logic [SAMPLE_W+RESULT_BITS-1:0]   data_ext;

	// Width fitting of channel and result
	assign chan_ext       = {{ADDRESS_BITS{1'b0}}, item.channel_number};
	assign chan_masked    = chan_ext[ADDRESS_BITS-1:0];
	assign data_ext       = {{SAMPLE_W{1'b0}}, data_sh_q};
	assign posted_from_sh = data_ext[SAMPLE_W-1:0];
	assign data_shifted   = (data_sh_q << 1) | RESULT_BITS'(item.data_out_level);
	assign dly_eff        = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
	assign bit_cnt_dec    = (bit_cnt_q != '0) ? bit_cnt_q - CNT_W'(1) : bit_cnt_q;

	// Next-state logic for one tick
	always_comb begin
		phase_d   = phase_q;
		bit_cnt_d = bit_cnt_q;
		dly_cnt_d = dly_cnt_q;
		addr_sh_d = addr_sh_q;
		data_sh_d = data_sh_q;
		posted_d  = posted_q;
		cs_d      = cs_q;
		clk_d     = clk_q;
		addr_d    = addr_q;
		valid_d   = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (item.start_request) begin
				addr_sh_d = chan_masked;
				data_sh_d = '0;
				bit_cnt_d = '0;
				phase_d   = PH_SEL;
				dly_cnt_d = DELAY_W'(1);
				cs_d      = 1'b0;
				clk_d     = 1'b0;
			end
		end else if (dly_cnt_q < dly_eff) begin
			dly_cnt_d = dly_cnt_q + DELAY_W'(1);
		end else begin
			// phase ends: every arm but the tail restarts the delay
			dly_cnt_d = DELAY_W'(1);
			unique case (phase_q)
				PH_SEL: begin
					bit_cnt_d = CNT_ADDR;
					addr_d    = addr_sh_q[ADDRESS_BITS-1];
					addr_sh_d = addr_sh_q << 1;
					phase_d   = PH_ASET; cs_d = 1'b0; clk_d = 1'b0;
				end
				PH_ASET: begin
					phase_d = PH_AHI; cs_d = 1'b0; clk_d = 1'b1;
				end
				PH_AHI: begin
					phase_d = PH_ALO; cs_d = 1'b0; clk_d = 1'b0;
				end
				PH_ALO: begin
					cs_d = 1'b0; clk_d = 1'b0;
					if (bit_cnt_dec != '0) begin
						bit_cnt_d = bit_cnt_dec;
						addr_d    = addr_sh_q[ADDRESS_BITS-1];
						addr_sh_d = addr_sh_q << 1;
						phase_d   = PH_ASET;
					end else begin
						bit_cnt_d = CNT_EXTRA;
						phase_d   = PH_XLO;
					end
				end
				PH_XLO: begin
					phase_d = PH_XHI; cs_d = 1'b0; clk_d = 1'b1;
				end
				PH_XHI: begin
					bit_cnt_d = bit_cnt_dec;
					clk_d     = 1'b0;
					if (bit_cnt_dec != '0) begin
						phase_d = PH_XLO; cs_d = 1'b0;
					end else begin
						phase_d = PH_PULSE; cs_d = 1'b1;
					end
				end
				PH_PULSE: begin
					bit_cnt_d = CNT_SLOW;
					data_sh_d = '0;
					phase_d   = PH_SHI1; cs_d = 1'b0; clk_d = 1'b1;
				end
				PH_SHI1: begin
					phase_d = PH_SHI2; cs_d = 1'b0; clk_d = 1'b1;
				end
				PH_SHI2: begin
					data_sh_d = data_shifted;
					phase_d   = PH_SLO; cs_d = 1'b0; clk_d = 1'b0;
				end
				PH_SLO: begin
					cs_d  = 1'b0;
					clk_d = 1'b1;
					if (bit_cnt_dec != '0) begin
						bit_cnt_d = bit_cnt_dec;
						phase_d   = PH_SHI1;
					end else begin
						bit_cnt_d = CNT_FAST;
						phase_d   = PH_FHI;
					end
				end
				PH_FHI: begin
					data_sh_d = data_shifted;
					phase_d   = PH_FLO; cs_d = 1'b0; clk_d = 1'b0;
				end
				PH_FLO: begin
					bit_cnt_d = bit_cnt_dec;
					cs_d      = 1'b0;
					if (bit_cnt_dec != '0) begin
						phase_d = PH_FHI; clk_d = 1'b1;
					end else begin
						phase_d = PH_TAIL; clk_d = 1'b0;
					end
				end
				default: begin
					// tail done: post the value and go idle
					posted_d  = posted_from_sh;
					valid_d   = 1'b1;
					phase_d   = PH_IDLE;
					dly_cnt_d = '0;
					bit_cnt_d = '0;
					cs_d      = 1'b1;
					clk_d     = 1'b0;
				end
			endcase
		end
	end

	// Result shows the levels after this tick's update
	always_comb begin
		res.chip_select_level = cs_d;
		res.io_clock_level    = clk_d;
		res.address_level     = addr_d;
		res.busy_flag         = (phase_d != PH_IDLE);
		res.sample_valid      = valid_d;
		res.sample_value      = posted_d;
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_cnt_q <= '0;
			dly_cnt_q <= '0;
			addr_sh_q <= '0;
			data_sh_q <= '0;
			posted_q  <= '0;
			cs_q      <= 1'b1;
			clk_q     <= 1'b0;
			addr_q    <= 1'b0;
		end else if (tick_en) begin
			phase_q   <= phase_d;
			bit_cnt_q <= bit_cnt_d;
			dly_cnt_q <= dly_cnt_d;
			addr_sh_q <= addr_sh_d;
			data_sh_q <= data_sh_d;
			posted_q  <= posted_d;
			cs_q      <= cs_d;
			clk_q     <= clk_d;
			addr_q    <= addr_d;
		end
	end

endmodule

// ----- tb/sar_tb_pkg.sv -----
`timescale 1ns / 1ps
// Pin sequence checker for the serial ADC readout master testbench: tick predictor and
// store of expected pin levels. Depends on sar_pkg for payload types and protocol constants.
package sar_tb_pkg;
	import sar_pkg::*;

	// Protocol steps of the readout sequence
	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_SELECT,
		SEQ_ADDR_SETUP,
		SEQ_ADDR_HIGH,
		SEQ_ADDR_LOW,
		SEQ_EXTRA_LOW,
		SEQ_EXTRA_HIGH,
		SEQ_CS_PULSE,
		SEQ_SLOW_HIGH_A,
		SEQ_SLOW_HIGH_B,
		SEQ_SLOW_LOW,
		SEQ_FAST_HIGH,
		SEQ_FAST_LOW,
		SEQ_TAIL
	} seq_phase_t;

	class adc_pin_checker;
		logic [DELAY_W-1:0]  delay_ticks;
		seq_phase_t          phase;
		int unsigned         bit_cnt;
		logic [DELAY_W-1:0]  dly_cnt;
		logic [CHAN_W-1:0]   addr_sr;
		logic [SAMPLE_W-1:0] data_sr;
		logic [SAMPLE_W-1:0] posted;
		logic                cs_pin;
		logic                clk_pin;
		logic                addr_pin;
		out_item_t           pins_q[$];
		int unsigned         fail_count;

		function new();
			delay_ticks = DELAY_W'(1);
			phase       = SEQ_IDLE;
			bit_cnt     = 0;
			dly_cnt     = '0;
			addr_sr     = '0;
			data_sr     = '0;
			posted      = '0;
			cs_pin      = 1'b1;
			clk_pin     = 1'b0;
			addr_pin    = 1'b0;
			fail_count  = 0;
		endfunction

		function void set_delay(logic [DELAY_W-1:0] v);
			delay_ticks = v;
		endfunction

		function bit busy();
			return phase != SEQ_IDLE;
		endfunction

		function int unsigned pending();
			return pins_q.size();
		endfunction

		function void enter_phase(seq_phase_t ph, logic cs, logic sclk);
			phase   = ph;
			dly_cnt = DELAY_W'(1);
			cs_pin  = cs;
			clk_pin = sclk;
		endfunction

		// Put the next channel bit on the address pin, MSB first
		function void drive_addr();
			addr_pin = addr_sr[CHAN_W-1];
			addr_sr  = addr_sr << 1;
		endfunction

		// Advance the sequencer by one accepted tick and queue the pin levels it shows
		function void note_tick(in_item_t t);
			logic [DELAY_W-1:0] lim;
			logic               strobe;
			out_item_t          e;
			lim    = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
			strobe = 1'b0;
			if (phase == SEQ_IDLE) begin
				if (t.start_request) begin
					addr_sr = t.channel_number;
					data_sr = '0;
					bit_cnt = 0;
					enter_phase(SEQ_SELECT, 1'b0, 1'b0);
				end
			end else if (dly_cnt < lim) begin
				dly_cnt++;
			end else begin
				case (phase)
					SEQ_SELECT: begin
						bit_cnt = CHAN_W;
						drive_addr();
						enter_phase(SEQ_ADDR_SETUP, 1'b0, 1'b0);
					end
					SEQ_ADDR_SETUP: enter_phase(SEQ_ADDR_HIGH, 1'b0, 1'b1);
					SEQ_ADDR_HIGH:  enter_phase(SEQ_ADDR_LOW, 1'b0, 1'b0);
					SEQ_ADDR_LOW: begin
						if (bit_cnt != 0) bit_cnt--;
						if (bit_cnt != 0) begin
							drive_addr();
							enter_phase(SEQ_ADDR_SETUP, 1'b0, 1'b0);
						end else begin
							bit_cnt = EXTRA_CLOCKS;
							enter_phase(SEQ_EXTRA_LOW, 1'b0, 1'b0);
						end
					end
					SEQ_EXTRA_LOW: enter_phase(SEQ_EXTRA_HIGH, 1'b0, 1'b1);
					SEQ_EXTRA_HIGH: begin
						if (bit_cnt != 0) bit_cnt--;
						if (bit_cnt != 0) enter_phase(SEQ_EXTRA_LOW, 1'b0, 1'b0);
						else enter_phase(SEQ_CS_PULSE, 1'b1, 1'b0);
					end
					SEQ_CS_PULSE: begin
						bit_cnt = SLOW_BITS;
						data_sr = '0;
						enter_phase(SEQ_SLOW_HIGH_A, 1'b0, 1'b1);
					end
					SEQ_SLOW_HIGH_A: enter_phase(SEQ_SLOW_HIGH_B, 1'b0, 1'b1);
					// data pin is taken where the clock falls
					SEQ_SLOW_HIGH_B: begin
						data_sr = {data_sr[SAMPLE_W-2:0], t.data_out_level};
						enter_phase(SEQ_SLOW_LOW, 1'b0, 1'b0);
					end
					SEQ_SLOW_LOW: begin
						if (bit_cnt != 0) bit_cnt--;
						if (bit_cnt != 0) begin
							enter_phase(SEQ_SLOW_HIGH_A, 1'b0, 1'b1);
						end else begin
							bit_cnt = SAMPLE_W - SLOW_BITS;
							enter_phase(SEQ_FAST_HIGH, 1'b0, 1'b1);
						end
					end
					SEQ_FAST_HIGH: begin
						data_sr = {data_sr[SAMPLE_W-2:0], t.data_out_level};
						enter_phase(SEQ_FAST_LOW, 1'b0, 1'b0);
					end
					SEQ_FAST_LOW: begin
						if (bit_cnt != 0) bit_cnt--;
						if (bit_cnt != 0) enter_phase(SEQ_FAST_HIGH, 1'b0, 1'b1);
						else enter_phase(SEQ_TAIL, 1'b0, 1'b0);
					end
					// end of tail: post the value, back to idle
					default: begin
						posted  = data_sr;
						strobe  = 1'b1;
						phase   = SEQ_IDLE;
						dly_cnt = '0;
						bit_cnt = 0;
						cs_pin  = 1'b1;
						clk_pin = 1'b0;
					end
				endcase
			end
			e.chip_select_level = cs_pin;
			e.io_clock_level    = clk_pin;
			e.address_level     = addr_pin;
			e.busy_flag         = (phase != SEQ_IDLE);
			e.sample_valid      = strobe;
			e.sample_value      = posted;
			pins_q.push_back(e);
		endfunction

		function void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
			if (exp_v != act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				fail_count++;
			end
		endfunction

		// Compare one output transfer with the oldest queued tick
		function void check_tick(out_item_t got);
			out_item_t e;
			if (pins_q.size() == 0) begin
				$error("output transfer with no tick waiting: %h", got);
				fail_count++;
				return;
			end
			e = pins_q.pop_front();
			cmp_field("chip_select_level", e.chip_select_level, got.chip_select_level);
			cmp_field("io_clock_level", e.io_clock_level, got.io_clock_level);
			cmp_field("address_level", e.address_level, got.address_level);
			cmp_field("busy_flag", e.busy_flag, got.busy_flag);
			cmp_field("sample_valid", e.sample_valid, got.sample_valid);
			cmp_field("sample_value", e.sample_value, got.sample_value);
		endfunction
	endclass

endpackage

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Top-level testbench for serial_adc_readout_master: drives ticks and delay settings,
// checks every output transfer. Depends on sar_pkg, sar_tb_pkg and the RTL.
module tb;
	import sar_pkg::*;
	import sar_tb_pkg::*;

	typedef enum int {DOUT_ZERO, DOUT_ONE, DOUT_RANDOM} dout_mode_t;

	localparam int RANDOM_TICKS = 140;
	localparam int LONG_TICKS   = 259;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [DELAY_W-1:0] cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_item_t          out_data;

	adc_pin_checker pin_chk;
	bit             gap_quiet;

	serial_adc_readout_master dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly back-to-back, a few long gaps
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic logic dout_level(dout_mode_t mode);
		case (mode)
			DOUT_ZERO: return 1'b0;
			DOUT_ONE:  return 1'b1;
			default:   return 1'($urandom_range(0, 1));
		endcase
	endfunction

	function automatic in_item_t make_tick(logic start, logic [CHAN_W-1:0] ch, logic dout);
		in_item_t t;
		t.start_request  = start;
		t.channel_number = ch;
		t.data_out_level = dout;
		return t;
	endfunction

	// One input transfer; called and left at a falling edge
	task automatic send_tick(in_item_t item, bit pause);
		int unsigned gap;
		gap = gap_quiet ? 0 : pick_gap();
		if (gap != 0 || pause) begin
			in_valid <= 1'b0;
			repeat ((gap != 0) ? gap : 1) @(negedge clk);
			while (pause && pin_chk.pending() != 0) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_stall);
		pin_chk.note_tick(item);
		@(negedge clk);
	endtask

	// Keep ticking until the sequencer is back to idle
	task automatic finish_sequence(bit hold_start, dout_mode_t mode);
		while (pin_chk.busy())
			send_tick(make_tick(hold_start, CHAN_W'($urandom_range(0, 15)),
				dout_level(mode)), 1'b0);
	endtask

	task automatic run_conversion(logic [CHAN_W-1:0] ch, dout_mode_t mode, bit hold_start);
		send_tick(make_tick(1'b1, ch, dout_level(mode)), 1'b0);
		finish_sequence(hold_start, mode);
	endtask

	// Stop sending and wait for every queued tick to come out
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pin_chk.pending() != 0) @(negedge clk);
	endtask

	task automatic write_delay(logic [DELAY_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		pin_chk.set_delay(v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Stimulus
	initial begin : stimulus
		logic [DELAY_W-1:0] delay_plan[7];
		in_item_t           t;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		arst_n      = 1'b0;
		gap_quiet   = 1'b0;
		pin_chk     = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset delay, channel extremes, data extremes, start held while busy
		send_tick(make_tick(1'b0, 4'hF, 1'b1), 1'b0);
		run_conversion(4'hF, DOUT_ONE, 1'b0);
		run_conversion(4'h0, DOUT_ZERO, 1'b1);
		run_conversion(4'hA, DOUT_RANDOM, 1'b1);
		run_conversion(4'h5, DOUT_RANDOM, 1'b0);
		send_tick(make_tick(1'b0, 4'h0, 1'b0), 1'b0);

		// delay settings incl. zero and the maximum
		delay_plan = '{8'd0, 8'd2, 8'd255, 8'd3, 8'd1, 8'd1, 8'd2};
		delay_plan[5] = DELAY_W'($urandom_range(1, 7));
		foreach (delay_plan[i]) begin
			settle();
			write_delay(delay_plan[i]);
			if (delay_plan[i] == 8'd255) begin
				// start at the longest delay; the next setting takes over mid-phase
				send_tick(make_tick(1'b1, CHAN_W'($urandom_range(0, 15)), 1'b0), 1'b0);
				repeat (LONG_TICKS)
					send_tick(make_tick(1'($urandom_range(0, 1)),
						CHAN_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
			end else begin
				repeat (RANDOM_TICKS) begin
					if ($urandom_range(0, 99) == 0) gap_quiet = !gap_quiet;
					t = make_tick(1'($urandom_range(0, 9) < 6), CHAN_W'($urandom_range(0, 15)),
						1'($urandom_range(0, 1)));
					send_tick(t, $urandom_range(0, 149) == 0);
				end
				finish_sequence(1'b0, DOUT_RANDOM);
			end
		end

		// drain and let the output register settle
		settle();
		repeat (8) @(posedge clk);
		if (pin_chk.pending() != 0)
			$error("%0d expected ticks never came out", pin_chk.pending());
		if (pin_chk.fail_count == 0 && pin_chk.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Output stall: short bursts, some long stalls, some free stretches
	initial begin : sink_stall
		int unsigned r;
		int unsigned stall_len;
		int unsigned free_len;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				stall_len = 0;
				free_len  = $urandom_range(40, 200);
			end else if (r < 14) begin
				stall_len = $urandom_range(10, 40);
				free_len  = $urandom_range(1, 4);
			end else begin
				stall_len = $urandom_range(0, 2);
				free_len  = $urandom_range(1, 5);
			end
			if (stall_len != 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(negedge clk);
			end
			out_stall <= 1'b0;
			repeat (free_len) @(negedge clk);
		end
	end

	// Check every output transfer
	initial begin : result_monitor
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) pin_chk.check_tick(out_data);
		end
	end

	initial begin : watchdog
		#60ms;
		$display("tb: failure");
		$finish;
	end

endmodule
